/* rtl/core/hesc_pkg.sv */
package hesc_pkg;

  // Longest escaped run (&quot;) and the width of a run length / byte index
  localparam int RUN_MAX = 6;
  localparam int LEN_W   = 3;

  typedef logic [7:0] byte_t;

  // Escaped form of one input byte, first byte in seq[0]
  typedef struct packed {
    byte_t [RUN_MAX-1:0] seq;
    logic  [LEN_W-1:0]   len;
  } run_t;

  // Escape mode codes
  localparam logic MODE_HTML = 1'b0;
  localparam logic MODE_URL  = 1'b1;

  // Character codes that steer the escaping
  localparam byte_t CH_AMP  = 8'h26;
  localparam byte_t CH_LT   = 8'h3C;
  localparam byte_t CH_GT   = 8'h3E;
  localparam byte_t CH_QUOT = 8'h22;
  localparam byte_t CH_PCT  = 8'h25;
  localparam byte_t CH_SEMI = 8'h3B;

  // Run lengths of the fixed escapes
  localparam logic [LEN_W-1:0] LEN_ONE  = 3'd1;
  localparam logic [LEN_W-1:0] LEN_HEX  = 3'd3;
  localparam logic [LEN_W-1:0] LEN_LTGT = 3'd4;
  localparam logic [LEN_W-1:0] LEN_AMP  = 3'd5;
  localparam logic [LEN_W-1:0] LEN_QUOT = 3'd6;

endpackage

/* rtl/core/hesc_encoder.sv */
module hesc_encoder (
  input  hesc_pkg::byte_t in_char,
  input  logic            mode,
  output hesc_pkg::run_t  run
);
  import hesc_pkg::*;

  // Uppercase hex digit for one nibble
  function automatic byte_t hex_digit(input logic [3:0] n);
    if (n < 4'd10) begin
      return 8'h30 + {4'b0000, n};
    end else begin
      return 8'h37 + {4'b0000, n};
    end
  endfunction

  // Letters, digits, byte zero and the safe punctuation pass in URL mode
  function automatic logic url_pass(input byte_t c);
    logic alnum;
    logic safe;
    alnum = (c >= "0" && c <= "9") || (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    safe  = (c == "-") || (c == "_") || (c == ".") || (c == "+") || (c == "!") ||
            (c == "*") || (c == 8'h27) || (c == "(") || (c == ")") || (c == ",") ||
            (c == CH_PCT) || (c == "#") || (c == "@") || (c == "?") || (c == "=") ||
            (c == CH_SEMI) || (c == ":") || (c == "/") || (c == "$");
    return (c == 8'h00) || alnum || safe;
  endfunction

  // Build the escaped run for one byte
  always_comb begin
    run        = '0;
    run.seq[0] = in_char;
    run.len    = LEN_ONE;
    if (mode == MODE_HTML || !url_pass(in_char)) begin
      priority if (in_char == CH_AMP) begin
        run.seq[0] = CH_AMP;
        run.seq[1] = "a";
        run.seq[2] = "m";
        run.seq[3] = "p";
        run.seq[4] = CH_SEMI;
        run.len    = LEN_AMP;
      end else if (mode == MODE_URL) begin
        run.seq[0] = CH_PCT;
        run.seq[1] = hex_digit(in_char[7:4]);
        run.seq[2] = hex_digit(in_char[3:0]);
        run.len    = LEN_HEX;
      end else if (in_char == CH_LT || in_char == CH_GT) begin
        run.seq[0] = CH_AMP;
        run.seq[1] = (in_char == CH_LT) ? "l" : "g";
        run.seq[2] = "t";
        run.seq[3] = CH_SEMI;
        run.len    = LEN_LTGT;
      end else if (in_char == CH_QUOT) begin
        run.seq[0] = CH_AMP;
        run.seq[1] = "q";
        run.seq[2] = "u";
        run.seq[3] = "o";
        run.seq[4] = "t";
        run.seq[5] = CH_SEMI;
        run.len    = LEN_QUOT;
      end else begin
        run.seq[0] = in_char;
        run.len    = LEN_ONE;
      end
    end
  end

endmodule

/* rtl/core/html_url_byte_escaper_core.sv */
// Byte escaper: each input transaction carries one text byte, and the core
// returns its escaped form as a run of one to six output transactions, one
// byte per cycle while out_stall is low. With escape_mode 0 it writes HTML
// entities for & < > and the double quote; with escape_mode 1 it
// percent-encodes every byte outside letters, digits, byte zero and the
// URL-safe punctuation (& becomes &amp;). An item holds the run stage until
// the last byte of its run (1, 3, 4, 5 or 6 bytes) is taken, and only then
// does the next item enter; bytes that pass through go at one item per cycle
// while out_stall is low. The first output byte passes the input, run and
// output registers. Write escape_mode only while the core holds no item.
module html_url_byte_escaper_core (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic                  cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  hesc_pkg::byte_t       in_byte,
  input  logic                  text_end,
  output logic                  out_valid,
  input  logic                  out_stall,
  output hesc_pkg::byte_t       out_byte,
  output logic                  last_of_run,
  output logic                  text_done
);
  import hesc_pkg::*;

  logic              escape_mode;
  logic              s1_valid;
  byte_t             s1_byte;
  logic              s1_end;
  run_t              enc_run;
  logic              rn_valid;
  run_t              rn;
  logic [LEN_W-1:0]  rn_idx;
  logic              rn_end;
  logic              out_load;
  logic              rn_last;
  logic              rn_pop;
  logic              rn_free;
  logic              s1_move;
  logic              in_accept;

  // Mode register
  always_ff @(posedge clk) begin
    if (rst) begin
      escape_mode <= MODE_HTML;
    end else if (cfg_write) begin
      escape_mode <= cfg_data;
    end
  end

  // Handshake and stage movement
  assign out_load  = !out_valid || !out_stall;
  assign rn_last   = (rn_idx == LEN_W'(rn.len - LEN_ONE));
  assign rn_pop    = rn_valid && out_load;
  assign rn_free   = !rn_valid || (rn_pop && rn_last);
  assign s1_move   = s1_valid && rn_free;
  assign in_stall  = s1_valid && !rn_free;
  assign in_accept = in_valid && !in_stall;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_accept) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_byte <= in_byte;
      s1_end  <= text_end;
    end
  end

  hesc_encoder u_encoder (
    .in_char (s1_byte),
    .mode    (escape_mode),
    .run     (enc_run)
  );

  // Run register: load a fresh run, advance one byte per output transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      rn_valid <= 1'b0;
      rn_idx   <= '0;
    end else if (s1_move) begin
      rn_valid <= 1'b1;
      rn_idx   <= '0;
    end else if (rn_pop && rn_last) begin
      rn_valid <= 1'b0;
      rn_idx   <= '0;
    end else if (rn_pop) begin
      rn_idx   <= rn_idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      rn     <= enc_run;
      rn_end <= s1_end;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= rn_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_byte    <= rn.seq[rn_idx];
      last_of_run <= rn_last;
      text_done   <= rn_last && rn_end;
    end
  end

endmodule

/* test/tb_html_url_byte_escaper_core.sv */
`timescale 1ns / 1ps

module tb_html_url_byte_escaper_core;
  import hesc_pkg::*;

  localparam int STALL_LIMIT = 2000;

  typedef struct packed {
    byte_t data;
    logic  last;
    logic  done;
  } escaped_byte_t;

  typedef byte_t byte_q_t[$];

  // Escape predictor plus the queue of output bytes still owed by the core
  class EscapeScoreboard;
    logic          mode;
    escaped_byte_t pending[$];
    int            errors;

    function new();
      mode   = MODE_HTML;
      errors = 0;
    endfunction

    static function byte_q_t spell(string s);
      byte_q_t q;
      for (int i = 0; i < s.len(); i++) q.push_back(byte_t'(s[i]));
      return q;
    endfunction

    static function byte_t hex_digit(logic [3:0] n);
      return (n < 10) ? byte_t'("0" + n) : byte_t'("A" + n - 10);
    endfunction

    static function bit url_passes(byte_t c);
      if (c == 8'h00) return 1'b1;
      if ((c >= "0" && c <= "9") || (c >= "a" && c <= "z") || (c >= "A" && c <= "Z"))
        return 1'b1;
      case (c)
        "-", "_", ".", "+", "!", "*", "'", "(", ")", ",",
        "%", "#", "@", "?", "=", ";", ":", "/", "$": return 1'b1;
        default: return 1'b0;
      endcase
    endfunction

    // Expand one accepted input byte into the run of output bytes it owes
    function void note_byte(byte_t c, logic fin);
      byte_q_t       run;
      escaped_byte_t item;
      if (mode == MODE_HTML) begin
        case (c)
          CH_AMP:  run = spell("&amp;");
          CH_LT:   run = spell("&lt;");
          CH_GT:   run = spell("&gt;");
          CH_QUOT: run = spell("&quot;");
          default: run = '{c};
        endcase
      end else if (url_passes(c)) begin
        run = '{c};
      end else if (c == CH_AMP) begin
        run = spell("&amp;");
      end else begin
        run = '{CH_PCT, hex_digit(c[7:4]), hex_digit(c[3:0])};
      end
      foreach (run[k]) begin
        item.data = run[k];
        item.last = (k == run.size() - 1);
        item.done = item.last & fin;
        pending.push_back(item);
      end
    endfunction

    // Compare one output transaction against the oldest owed byte
    function void check_out(byte_t b, logic l, logic d);
      escaped_byte_t want;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: unexpected output: out_byte %h last_of_run %b text_done %b",
                 $time, b, l, d);
        return;
      end
      want = pending.pop_front();
      if (b !== want.data) begin
        errors++;
        $display("%0t: out_byte mismatch: expected %h, actual %h", $time, want.data, b);
      end
      if (l !== want.last) begin
        errors++;
        $display("%0t: last_of_run mismatch: expected %b, actual %b", $time, want.last, l);
      end
      if (d !== want.done) begin
        errors++;
        $display("%0t: text_done mismatch: expected %b, actual %b", $time, want.done, d);
      end
    endfunction
  endclass

  logic  clk       = 1'b0;
  logic  rst       = 1'b1;
  logic  cfg_write = 1'b0;
  logic  cfg_data  = 1'b0;
  logic  in_valid  = 1'b0;
  logic  in_stall;
  byte_t in_byte   = 8'h00;
  logic  text_end  = 1'b0;
  logic  out_valid;
  logic  out_stall = 1'b0;
  byte_t out_byte;
  logic  last_of_run;
  logic  text_done;

  EscapeScoreboard board;
  int              idle_cycles = 0;

  html_url_byte_escaper_core u_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_byte     (in_byte),
    .text_end    (text_end),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_byte    (out_byte),
    .last_of_run (last_of_run),
    .text_done   (text_done)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Mostly short gaps, now and then a long one
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 20);
  endfunction

  // Bias the byte mix toward the characters that steer the escaping
  function automatic byte_t pick_byte();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return byte_t'($urandom_range(0, 255));
      4, 5: begin
        case ($urandom_range(0, 15))
          0:  return CH_AMP;
          1:  return CH_LT;
          2:  return CH_GT;
          3:  return CH_QUOT;
          4:  return "'";
          5:  return 8'h00;
          6:  return CH_PCT;
          7:  return "-";
          8:  return "$";
          9:  return "/";
          10: return " ";
          11: return 8'h7F;
          12: return 8'h80;
          13: return 8'hFF;
          14: return "@";
          default: return "~";
        endcase
      end
      6, 7: begin
        case ($urandom_range(0, 2))
          0:       return byte_t'("0" + $urandom_range(0, 9));
          1:       return byte_t'("a" + $urandom_range(0, 25));
          default: return byte_t'("A" + $urandom_range(0, 25));
        endcase
      end
      default: return byte_t'($urandom_range(8'h20, 8'h7E));
    endcase
  endfunction

  // Present one transaction and hold it until the core takes it
  task automatic send_byte(byte_t b, logic fin, int unsigned gap);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    text_end <= fin;
    do @(posedge clk); while (in_stall !== 1'b0);
    board.note_byte(b, fin);
  endtask

  // Hold the input until every owed byte is out, then let the pipeline settle
  task automatic wait_drain();
    in_valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic set_mode(logic m);
    wait_drain();
    cfg_write <= 1'b1;
    cfg_data  <= m;
    @(posedge clk);
    cfg_write <= 1'b0;
    board.mode = m;
  endtask

  task automatic send_list(byte_q_t list);
    foreach (list[k]) send_byte(list[k], logic'(k % 2), idle_len());
  endtask

  // Texts of random length ending in text_end; a few carry stray end marks
  task automatic send_texts(int n);
    int          sent;
    int unsigned len;
    bit          quiet;
    bit          broken;
    logic        fin;
    sent = 0;
    while (sent < n) begin
      len    = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 30) : $urandom_range(1, 8);
      quiet  = ($urandom_range(0, 4) == 0);
      broken = ($urandom_range(0, 7) == 0);
      for (int k = 0; k < len; k++) begin
        fin = broken ? logic'($urandom_range(0, 1)) : logic'(k == len - 1);
        send_byte(pick_byte(), fin, quiet ? 0 : idle_len());
      end
      sent += len;
    end
  endtask

  // Stall the output in random bursts separated by free stretches
  initial begin
    int unsigned n;
    forever begin
      n = idle_len();
      if (n != 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end
      repeat (($urandom_range(0, 9) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 6))
        @(posedge clk);
    end
  end

  // Check every output transaction
  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0)
      board.check_out(out_byte, last_of_run, text_done);
  end

  // End the run if no transaction moves for too long
  always @(posedge clk) begin
    if (rst || (in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles == STALL_LIMIT) begin
      $display("tb_html_url_byte_escaper_core: errors");
      $finish;
    end
  end

  initial begin
    board = new();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed: entity characters and extremes in the reset mode
    send_list('{CH_AMP, CH_LT, CH_GT, CH_QUOT, 8'h00, 8'hFF, "a", "'"});

    // Directed: pass-through, ampersand, quote and hex cases in URL mode
    set_mode(MODE_URL);
    send_list('{8'h00, 8'hFF, 8'h80, CH_AMP, "'", "Z", "9", "-", "$", "/", " ",
                CH_LT, 8'h7F, CH_QUOT, "~"});

    // Random texts, alternating modes, with a full drain after the first batch
    send_texts(65);
    wait_drain();
    send_texts(65);
    set_mode(MODE_HTML);
    send_texts(125);
    set_mode(MODE_URL);
    send_texts(120);
    set_mode(MODE_HTML);
    send_texts(120);

    wait_drain();
    repeat (20) @(posedge clk);
    if (board.errors == 0 && board.pending.size() == 0)
      $display("tb_html_url_byte_escaper_core: clean");
    else
      $display("tb_html_url_byte_escaper_core: errors");
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/hesc_pkg.sv
rtl/core/hesc_encoder.sv
rtl/core/html_url_byte_escaper_core.sv
test/tb_html_url_byte_escaper_core.sv
